// ===== design/shd_pkg.sv =====
// Package for the sliding Hann-windowed DCT core: sizes, types and constant tables.
package shd_pkg;

	localparam int WINDOW    = 64;
	localparam int MAX_COEFS = 32;
	localparam int COS_LEN   = 4 * WINDOW;
	localparam int HANN_DEN  = WINDOW - 1;

	localparam int SAMPLE_W     = 16;
	localparam int HANN_W       = 16;
	localparam int COS_W        = 16;
	localparam int W_W          = 24;
	localparam int CFG_W        = 6;
	localparam int COEF_INDEX_W = 5;
	localparam int COEF_VALUE_W = 25;

	localparam int SLOT_W    = $clog2(WINDOW);
	localparam int SEEN_W    = $clog2(WINDOW + 2);
	localparam int COS_IDX_W = $clog2(COS_LEN);
	localparam int K_W       = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
	localparam int CNT_W     = $clog2(MAX_COEFS + 1);

	localparam int PH_W   = SAMPLE_W + HANN_W;
	localparam int PROD_W = W_W + COS_W;
	localparam int ACC_W  = PROD_W + $clog2(WINDOW);
	localparam int DIV_SH = $clog2(WINDOW) + 14;
	localparam int Y_W    = ACC_W + 1 - DIV_SH;
	localparam int Z_W    = Y_W + 16;
	localparam int V_W    = Z_W + 1 - 15;

	localparam logic [CFG_W-1:0] COEF_COUNT_RESET = CFG_W'(32);
	localparam logic signed [15:0] INV_SQRT2_Q15 = 16'sd23170;
	localparam longint SAT_HI = (64'sd1 <<< (COEF_VALUE_W - 1)) - 64'sd1;
	localparam longint SAT_LO = -(64'sd1 <<< (COEF_VALUE_W - 1));

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned COS_DIV [8] = '{1, 2, 12, 30, 56, 90, 132, 182};
	localparam longint unsigned SIN_DIV [8] = '{1, 6, 20, 42, 72, 110, 156, 210};

	typedef logic signed [HANN_W-1:0] hann_tab_t [WINDOW];
	typedef logic signed [COS_W-1:0]  cos_tab_t  [COS_LEN];

	// One weighted sample moving down the cell row.
	typedef struct packed {
		logic                  valid;
		logic                  last;
		logic signed [W_W-1:0] w;
	} tap_t;

	// Truncated Taylor series in Q30: cosine, or sine when odd is set.
	function automatic longint series_q30(input longint unsigned x, input bit odd);
		longint unsigned term;
		longint          sum;
		term = odd ? x : (64'd1 << 30);
		sum  = longint'(term);
		for (int j = 1; j <= 7; j++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = odd ? term / SIN_DIV[j] : term / COS_DIV[j];
			if ((j & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return sum;
	endfunction

	// Unclamped Q15 cosine of a 32-bit phase, rounded half away from zero.
	function automatic int cos_from_phase(input longint unsigned ph);
		logic [1:0]      quad;
		longint unsigned r;
		longint unsigned x;
		longint          v;
		quad = ph[31:30];
		r    = ph & 64'h3FFF_FFFF;
		x    = (r * HALF_PI_Q30) >> 30;
		if (quad == 2'd0) begin
			v = series_q30(x, 1'b0);
		end else if (quad == 2'd1) begin
			v = -series_q30(x, 1'b1);
		end else if (quad == 2'd2) begin
			v = -series_q30(x, 1'b0);
		end else begin
			v = series_q30(x, 1'b1);
		end
		if (v < 0) begin
			return -int'((-v + 64'sd16384) >>> 15);
		end
		return int'((v + 64'sd16384) >>> 15);
	endfunction

	function automatic hann_tab_t build_hann();
		hann_tab_t       t;
		longint unsigned ph;
		int              c;
		int              h;
		for (int i = 0; i < WINDOW; i++) begin
			ph = longint'((longint'(i % HANN_DEN) << 32) / HANN_DEN);
			c  = cos_from_phase(ph);
			h  = (32768 - c + 1) >>> 1;
			if (h > 32767) begin
				h = 32767;
			end
			t[i] = HANN_W'(h);
		end
		return t;
	endfunction

	function automatic cos_tab_t build_cos();
		cos_tab_t        t;
		longint unsigned ph;
		int              c;
		for (int i = 0; i < COS_LEN; i++) begin
			ph = longint'((longint'(i) << 32) / COS_LEN);
			c  = cos_from_phase(ph);
			if (c > 32767) begin
				c = 32767;
			end
			if (c < -32768) begin
				c = -32768;
			end
			t[i] = COS_W'(c);
		end
		return t;
	endfunction

	localparam hann_tab_t HANN_TAB = build_hann();
	localparam cos_tab_t  COS_TAB  = build_cos();

	// Circular slot advance.
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(WINDOW - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

// ===== design/shd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module shd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/shd_cell.sv =====
// One coefficient cell: cosine lookup, multiply, accumulate, and a result shift stage.
module shd_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [shd_pkg::K_W-1:0]          cell_idx,
	input  logic                             clear,
	input  shd_pkg::tap_t                    tap_in,
	output shd_pkg::tap_t                    tap_out,
	input  logic                             load,
	input  logic                             shift,
	input  logic signed [shd_pkg::ACC_W-1:0] res_in,
	output logic signed [shd_pkg::ACC_W-1:0] res_out
);

	logic                                 valid_s1;
	logic                                 last_s1;
	logic signed [shd_pkg::W_W-1:0]       w_s1;
	logic signed [shd_pkg::COS_W-1:0]     cos_s1;
	logic                                 valid_s2;
	logic signed [shd_pkg::PROD_W-1:0]    prod_s2;
	logic [shd_pkg::COS_IDX_W-1:0]        m_q;
	logic signed [shd_pkg::ACC_W-1:0]     acc_q;
	logic signed [shd_pkg::ACC_W-1:0]     res_q;
	logic [shd_pkg::COS_IDX_W:0]          m_sum;
	logic [shd_pkg::COS_IDX_W-1:0]        m_next;
	logic [shd_pkg::COS_IDX_W-1:0]        m_init;

	// The cosine index for term n is (2n+1)k, so it starts at k and steps by 2k.
	assign m_init = shd_pkg::COS_IDX_W'(cell_idx);
	assign m_sum  = {1'b0, m_q} + (shd_pkg::COS_IDX_W + 1)'({cell_idx, 1'b0});
	assign m_next = (m_sum >= (shd_pkg::COS_IDX_W + 1)'(shd_pkg::COS_LEN))
		? shd_pkg::COS_IDX_W'(m_sum - (shd_pkg::COS_IDX_W + 1)'(shd_pkg::COS_LEN))
		: shd_pkg::COS_IDX_W'(m_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			m_q      <= '0;
		end else begin
			valid_s1 <= tap_in.valid;
			last_s1  <= tap_in.valid & tap_in.last;
			valid_s2 <= valid_s1;
			if (clear) begin
				m_q <= m_init;
			end else if (tap_in.valid) begin
				m_q <= m_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tap_in.valid) begin
			w_s1   <= tap_in.w;
			cos_s1 <= shd_pkg::COS_TAB[m_q];
		end
		if (valid_s1) begin
			prod_s2 <= w_s1 * cos_s1;
		end
		if (clear) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + shd_pkg::ACC_W'(prod_s2);
		end
		if (load) begin
			res_q <= acc_q;
		end else if (shift) begin
			res_q <= res_in;
		end
	end

	assign tap_out = '{valid: valid_s1, last: last_s1, w: w_s1};
	assign res_out = res_q;

endmodule

// ===== design/sliding_hann_dct_core.sv =====
// Top level of the sliding Hann-windowed DCT-II core.
//
// The core keeps the last 64 signed samples in a RAM. Each sample transaction
// writes one entry. Once more than 64 samples have been seen, every new sample
// starts a window: the RAM is read oldest first, one sample per cycle, each
// sample is multiplied by its Hann weight and rounded to Q8, and the weighted
// stream walks down a row of 32 cells, one cell per coefficient, moving one
// cell per cycle. Each cell multiplies by its own cosine and accumulates in
// full precision. When the stream has left the last cell, all accumulators are
// copied into a result shift row, and the core returns to accepting samples
// while the results drain: coefficient k is rounded by 2/WINDOW (and by
// 1/sqrt(2) for k = 0), saturated to Q17.8, and delivered in index order with
// last_coef on the final one. Only the first coef_count coefficients are sent
// (values above 32 act as 32, zero sends nothing). A sample that starts no
// window leaves the core ready for the next sample. A sample that starts a
// window holds off the next sample transaction until the RAM sweep, the three
// front-end stages, the trip of the last sample through the cell row and the
// fin_s1 and chain_done_q flags that mark the row as finished are through.
// The result transactions of one window overlap the next window's sweep, and
// a new window's accumulators are handed over only once the previous window's
// results have all left the shift row. coef_count is written through cfg_we
// and cfg_wdata and resets to 32.
module sliding_hann_dct_core (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [shd_pkg::CFG_W-1:0]                cfg_wdata,
	input  logic                                     sample_valid,
	output logic                                     sample_ready,
	input  logic signed [shd_pkg::SAMPLE_W-1:0]      sample,
	output logic                                     coef_valid,
	input  logic                                     coef_ready,
	output logic [shd_pkg::COEF_INDEX_W-1:0]         coef_index,
	output logic signed [shd_pkg::COEF_VALUE_W-1:0]  coef_value,
	output logic                                     last_coef
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]                           state_q;
	logic [shd_pkg::CFG_W-1:0]            coef_count_q;
	logic [shd_pkg::SLOT_W-1:0]           write_slot_q;
	logic [shd_pkg::SEEN_W-1:0]           seen_q;
	logic [shd_pkg::SLOT_W-1:0]           rd_slot_q;
	logic [shd_pkg::SLOT_W-1:0]           rd_n_q;
	logic [shd_pkg::CNT_W-1:0]            cnt_q;
	logic [shd_pkg::CNT_W-1:0]            cnt_eff;
	logic                                 chain_done_q;
	logic                                 fin_s1;

	logic                                 accept;
	logic                                 start_win;
	logic                                 rd_fire;
	logic                                 rd_last;
	logic                                 load;

	// Hann weighting front end.
	logic [shd_pkg::SAMPLE_W-1:0]         ram_rdata;
	logic                                 valid_s1;
	logic                                 last_s1;
	logic signed [shd_pkg::HANN_W-1:0]    h_s1;
	logic                                 valid_s2;
	logic                                 last_s2;
	logic signed [shd_pkg::PH_W-1:0]      p_s2;
	logic signed [shd_pkg::PH_W:0]        p_rnd;
	logic                                 valid_s3;
	logic                                 last_s3;
	logic signed [shd_pkg::W_W-1:0]       w_s3;

	// Cell row.
	shd_pkg::tap_t                        tap_w [shd_pkg::MAX_COEFS+1];
	logic signed [shd_pkg::ACC_W-1:0]     res_w [shd_pkg::MAX_COEFS+1];

	// Result drain and output path.
	logic [shd_pkg::CNT_W-1:0]            drain_cnt_q;
	logic [shd_pkg::K_W-1:0]              out_k_q;
	logic                                 pop;
	logic                                 out_adv;
	logic                                 p1_adv;
	logic                                 p2_adv;
	logic signed [shd_pkg::ACC_W:0]       y_sum;
	logic                                 v_p1;
	logic signed [shd_pkg::Y_W-1:0]       y_p1;
	logic [shd_pkg::K_W-1:0]              k_p1;
	logic                                 last_p1;
	logic                                 v_p2;
	logic signed [shd_pkg::Z_W-1:0]       z_p2;
	logic [shd_pkg::K_W-1:0]              k_p2;
	logic                                 last_p2;
	logic signed [shd_pkg::Z_W:0]         v_sum;
	logic signed [shd_pkg::V_W-1:0]       v_rnd;
	logic signed [shd_pkg::COEF_VALUE_W-1:0] v_sat;
	logic                                 coef_valid_q;
	logic [shd_pkg::COEF_INDEX_W-1:0]     coef_index_q;
	logic signed [shd_pkg::COEF_VALUE_W-1:0] coef_value_q;
	logic                                 last_coef_q;

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;

	// Register values above the cell count behave as the full cell count.
	assign cnt_eff = (int'(coef_count_q) > shd_pkg::MAX_COEFS)
		? shd_pkg::CNT_W'(shd_pkg::MAX_COEFS)
		: shd_pkg::CNT_W'(coef_count_q);

	// A window starts once the store already holds a full window before this sample and the coefficient count is not zero.
	assign start_win = accept && (seen_q >= shd_pkg::SEEN_W'(shd_pkg::WINDOW))
		&& (cnt_eff != '0);

	assign rd_fire = (state_q == ST_READ);
	assign rd_last = (rd_n_q == shd_pkg::SLOT_W'(shd_pkg::WINDOW - 1));
	assign load    = (state_q == ST_WAIT) && chain_done_q && (drain_cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			coef_count_q <= shd_pkg::COEF_COUNT_RESET;
			write_slot_q <= '0;
			seen_q       <= '0;
			rd_slot_q    <= '0;
			rd_n_q       <= '0;
			cnt_q        <= '0;
			chain_done_q <= 1'b0;
			fin_s1       <= 1'b0;
		end else begin
			if (cfg_we) begin
				coef_count_q <= cfg_wdata;
			end
			if (accept) begin
				write_slot_q <= shd_pkg::next_slot(write_slot_q);
				if (seen_q != shd_pkg::SEEN_W'(shd_pkg::WINDOW + 1)) begin
					seen_q <= seen_q + 1'b1;
				end
			end
			fin_s1 <= tap_w[shd_pkg::MAX_COEFS].valid & tap_w[shd_pkg::MAX_COEFS].last;
			if (start_win) begin
				chain_done_q <= 1'b0;
			end else if (fin_s1) begin
				chain_done_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start_win) begin
						state_q   <= ST_READ;
						// Oldest sample sits just past the slot written now.
						rd_slot_q <= shd_pkg::next_slot(write_slot_q);
						rd_n_q    <= '0;
						cnt_q     <= cnt_eff;
					end
				end
				ST_READ: begin
					rd_slot_q <= shd_pkg::next_slot(rd_slot_q);
					rd_n_q    <= rd_n_q + 1'b1;
					if (rd_last) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	shd_ram #(
		.WIDTH (shd_pkg::SAMPLE_W),
		.DEPTH (shd_pkg::WINDOW)
	) u_window_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (write_slot_q),
		.wdata (sample),
		.raddr (rd_slot_q),
		.rdata (ram_rdata)
	);

	// Front end: RAM read and Hann lookup, product, then rounding to Q8.
	assign p_rnd = $signed({p_s2[shd_pkg::PH_W-1], p_s2})
		+ $signed((shd_pkg::PH_W + 1)'(p_s2[shd_pkg::PH_W-1] ? 63 : 64));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			valid_s3 <= 1'b0;
			last_s3  <= 1'b0;
		end else begin
			valid_s1 <= rd_fire;
			last_s1  <= rd_fire & rd_last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			valid_s3 <= valid_s2;
			last_s3  <= last_s2;
		end
	end

	always_ff @(posedge clk) begin
		h_s1 <= shd_pkg::HANN_TAB[rd_n_q];
		if (valid_s1) begin
			p_s2 <= $signed(ram_rdata) * h_s1;
		end
		if (valid_s2) begin
			w_s3 <= shd_pkg::W_W'(p_rnd >>> 7);
		end
	end

	assign tap_w[0] = '{valid: valid_s3, last: last_s3, w: w_s3};
	assign res_w[shd_pkg::MAX_COEFS] = '0;

	for (genvar i = 0; i < shd_pkg::MAX_COEFS; i++) begin : g_cell
		shd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (shd_pkg::K_W'(i)),
			.clear    (start_win),
			.tap_in   (tap_w[i]),
			.tap_out  (tap_w[i+1]),
			.load     (load),
			.shift    (pop),
			.res_in   (res_w[i+1]),
			.res_out  (res_w[i])
		);
	end

	// Drain: the head of the result row is scaled, trimmed and handed out.
	assign out_adv = !coef_valid_q || coef_ready;
	assign p2_adv  = !v_p2 || out_adv;
	assign p1_adv  = !v_p1 || p2_adv;
	assign pop     = (drain_cnt_q != '0) && p1_adv;

	assign y_sum = $signed({res_w[0][shd_pkg::ACC_W-1], res_w[0]})
		+ $signed((shd_pkg::ACC_W + 1)'(res_w[0][shd_pkg::ACC_W-1]
			? (2 ** (shd_pkg::DIV_SH - 1)) - 1 : 2 ** (shd_pkg::DIV_SH - 1)));

	assign v_sum = $signed({z_p2[shd_pkg::Z_W-1], z_p2})
		+ $signed((shd_pkg::Z_W + 1)'(z_p2[shd_pkg::Z_W-1] ? 16383 : 16384));
	assign v_rnd = shd_pkg::V_W'(v_sum >>> 15);

	always_comb begin
		if (v_rnd > shd_pkg::SAT_HI) begin
			v_sat = shd_pkg::COEF_VALUE_W'(shd_pkg::SAT_HI);
		end else if (v_rnd < shd_pkg::SAT_LO) begin
			v_sat = shd_pkg::COEF_VALUE_W'(shd_pkg::SAT_LO);
		end else begin
			v_sat = shd_pkg::COEF_VALUE_W'(v_rnd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_cnt_q  <= '0;
			out_k_q      <= '0;
			v_p1         <= 1'b0;
			v_p2         <= 1'b0;
			coef_valid_q <= 1'b0;
		end else begin
			if (load) begin
				drain_cnt_q <= cnt_q;
				out_k_q     <= '0;
			end else if (pop) begin
				drain_cnt_q <= drain_cnt_q - 1'b1;
				out_k_q     <= out_k_q + 1'b1;
			end
			if (p1_adv) begin
				v_p1 <= pop;
			end
			if (p2_adv) begin
				v_p2 <= v_p1;
			end
			if (out_adv) begin
				coef_valid_q <= v_p2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			y_p1    <= shd_pkg::Y_W'(y_sum >>> shd_pkg::DIV_SH);
			k_p1    <= out_k_q;
			last_p1 <= (drain_cnt_q == shd_pkg::CNT_W'(1));
		end
		if (p2_adv && v_p1) begin
			// Coefficient 0 carries the extra 1/sqrt(2); the others are aligned
			// to the same Q15 scale so one rounding stage serves both.
			if (k_p1 == '0) begin
				z_p2 <= y_p1 * shd_pkg::INV_SQRT2_Q15;
			end else begin
				z_p2 <= $signed({y_p1[shd_pkg::Y_W-1], y_p1, 15'b0});
			end
			k_p2    <= k_p1;
			last_p2 <= last_p1;
		end
		if (out_adv && v_p2) begin
			coef_index_q <= shd_pkg::COEF_INDEX_W'(k_p2);
			coef_value_q <= v_sat;
			last_coef_q  <= last_p2;
		end
	end

	assign coef_valid = coef_valid_q;
	assign coef_index = coef_index_q;
	assign coef_value = coef_value_q;
	assign last_coef  = last_coef_q;

	// The weighting front end is empty whenever a new sample can be taken.
	a_front_empty_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready |-> !(valid_s1 || valid_s2 || valid_s3))
		else $error("front end busy while accepting samples");

	// The cell row cannot report completion while the window is still being read.
	a_no_done_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> !chain_done_q)
		else $error("cell row done during RAM sweep");

	// A coefficient that is not the last one must have successors in flight.
	a_successor_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(coef_valid && !last_coef) |-> ((drain_cnt_q != '0) || v_p1 || v_p2))
		else $error("window ended without a last coefficient");

	a_drain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (drain_cnt_q <= shd_pkg::CNT_W'(shd_pkg::MAX_COEFS)))
		else $error("result count above cell count");

endmodule
